### rtl/core/kml_pkg.sv
// Shared types, codes and default sizes for the k-means clustering core.
package kml_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int COORD_BITS_DEF   = 16;

  localparam logic [2:0] FUNC_LOAD_POINT  = 3'd0;
  localparam logic [2:0] FUNC_LOAD_CENTER = 3'd1;
  localparam logic [2:0] FUNC_START       = 3'd2;
  localparam logic [2:0] FUNC_READ_LABEL  = 3'd3;
  localparam logic [2:0] FUNC_READ_CENTER = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_LABEL  = 2'd1;
  localparam logic [1:0] KIND_CENTER = 2'd2;

  localparam logic [1:0] CFG_NUM_POINTS   = 2'd0;
  localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd1;
  localparam logic [1:0] CFG_NUM_DIMS     = 2'd2;
  localparam logic [1:0] CFG_MAX_PASSES   = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [9:0]         point_index;
    logic [3:0]         center_index;
    logic [2:0]         dim_index;
    logic signed [15:0] value;
  } kml_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         label;
    logic signed [15:0] coordinate;
    logic [15:0]        passes_run;
    logic               converged;
  } kml_out_t;

  typedef struct packed {
    logic clr_sums;
    logic clr_dist;
    logic dist_en;
    logic add_en;
    logic cnt_inc;
    logic wr_en;
  } kml_cell_ctl_t;

endpackage

### rtl/core/kml_div.sv
// Restoring divider, one quotient bit per cycle.
module kml_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### rtl/core/kml_cell.sv
// One cluster cell: center, distance unit, running sums and the best-match chain stage.
module kml_cell import kml_pkg::*; #(
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SUM_W      = 27,
  parameter int CNT_W      = 11,
  parameter int DIST_W     = 38,
  parameter int IDX_W      = 4,
  localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kml_cell_ctl_t                ctl,
  input  logic                         sel,
  input  logic                         active,
  input  logic [IDX_W-1:0]             cell_idx,
  input  logic [DIM_W-1:0]             bus_dim,
  input  logic signed [COORD_BITS-1:0] bus_coord,
  input  logic                         ch_v_i,
  input  logic                         ch_have_i,
  input  logic [DIST_W-1:0]            ch_dist_i,
  input  logic [IDX_W-1:0]             ch_idx_i,
  output logic                         ch_v_o,
  output logic                         ch_have_o,
  output logic [DIST_W-1:0]            ch_dist_o,
  output logic [IDX_W-1:0]             ch_idx_o,
  output logic signed [COORD_BITS-1:0] coord_o,
  output logic signed [SUM_W-1:0]      sum_o,
  output logic [CNT_W-1:0]             cnt_o
);

  logic signed [COORD_BITS-1:0] center_r [MAX_DIMS];
  logic signed [SUM_W-1:0]      sum_r [MAX_DIMS];
  logic [CNT_W-1:0]             cnt_r;
  logic [COORD_BITS:0]          diff_r;
  logic [2*COORD_BITS+1:0]      sq_r;
  logic [DIST_W-1:0]            acc_r;
  logic                         v1_r;
  logic                         v2_r;
  logic signed [COORD_BITS:0]   delta;
  logic [COORD_BITS:0]          mag;

  assign delta = (COORD_BITS+1)'(bus_coord) - (COORD_BITS+1)'(center_r[bus_dim]);
  assign mag   = delta[COORD_BITS] ? (COORD_BITS+1)'(-delta) : (COORD_BITS+1)'(delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ch_v_o <= 1'b0;
    end else begin
      v1_r   <= ctl.dist_en;
      v2_r   <= v1_r;
      ch_v_o <= ch_v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dist_en) begin
      diff_r <= mag;
    end
    if (v1_r) begin
      sq_r <= diff_r * diff_r;
    end
    if (ctl.clr_dist) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + DIST_W'(sq_r);
    end
    if (ctl.clr_sums) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        sum_r[d] <= '0;
      end
      cnt_r <= '0;
    end else begin
      if (ctl.add_en && sel) begin
        sum_r[bus_dim] <= sum_r[bus_dim] + SUM_W'(bus_coord);
      end
      if (ctl.cnt_inc && sel) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (ctl.wr_en && sel) begin
      center_r[bus_dim] <= bus_coord;
    end
    if (ch_v_i) begin
      if (active && (!ch_have_i || acc_r < ch_dist_i)) begin
        ch_have_o <= 1'b1;
        ch_dist_o <= acc_r;
        ch_idx_o  <= cell_idx;
      end else begin
        ch_have_o <= ch_have_i;
        ch_dist_o <= ch_dist_i;
        ch_idx_o  <= ch_idx_i;
      end
    end
  end

  assign coord_o = center_r[bus_dim];
  assign sum_o   = sum_r[bus_dim];
  assign cnt_o   = cnt_r;

endmodule

### rtl/core/kmeans_lloyd_clustering_core.sv
// Lloyd k-means core: loads, pass sequencer, cluster cell chain, mean divider and readback.
// Loads give no result; label and center reads return a registered beat via ST_RDL or ST_RDC.
// A start runs passes; each pass sweeps N points over D dims through the K = MAX_CLUSTERS cells
// of the compare chain, then updates the mean of every non-empty cluster, dimension by dimension,
// in the shared mean divider; empty clusters keep their centers.
// Reset is synchronous: control and configuration return to defaults; stores are not cleared.
module kmeans_lloyd_clustering_core import kml_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = MAX_DIMS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kml_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kml_out_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int KW     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_BITS + CNT_W + 1;
  localparam int DIST_W = 2 * COORD_BITS + 3 + $clog2(MAX_DIMS);
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDL, ST_RDC, ST_PASS, ST_PT, ST_WAIT, ST_CHAIN,
    ST_ACC, ST_DRAIN, ST_UPD, ST_DIV, ST_NEXT, ST_PEND, ST_DONE
  } state_t;

  state_t state_r;

  logic [10:0] num_points_r;
  logic [4:0]  num_clusters_r;
  logic [3:0]  num_dims_r;
  logic [15:0] max_passes_r;

  logic [PW-1:0] np_m1, np_m1_r;
  logic [KW-1:0] nk_m1, nk_m1_r;
  logic [DW-1:0] nd_m1, nd_m1_r;
  logic [15:0]   limit, limit_r;

  logic [PW-1:0] p_r;
  logic [DW-1:0] d_r;
  logic [1:0]    wt_r;
  logic [KW-1:0] tgt_r;
  logic [DW-1:0] wr_dim_r;
  logic signed [COORD_BITS-1:0] wr_coord_r;
  logic          ld_r;
  logic          upd_r;
  logic [15:0]   pass_r;
  logic [15:0]   pass_inc;
  logic          changed_r;
  logic          conv_r;
  logic          ch_v_r;
  logic          iss_v_r;
  logic          iss_add_r;
  logic [DW-1:0] iss_dim_r;
  logic          sign_r;
  logic          out_valid_r;
  kml_out_t      out_data_r;

  logic          accept;
  logic          gives_result;
  logic [PW-1:0] in_pi;
  logic [KW-1:0] in_ci;
  logic [DW-1:0] in_di;
  logic signed [COORD_BITS-1:0] in_coord;

  logic signed [COORD_BITS-1:0] pmem [DEPTH];
  logic signed [COORD_BITS-1:0] pmem_q;
  logic          pm_we;
  logic [AW-1:0] pm_waddr;
  logic [AW-1:0] pm_raddr;

  logic [KW-1:0] lmem [MAX_POINTS];
  logic [KW-1:0] lmem_q;
  logic          lm_we;
  logic [PW-1:0] lm_raddr;

  kml_cell_ctl_t ctl;
  logic [DW-1:0] bus_dim;
  logic signed [COORD_BITS-1:0] bus_coord;

  logic              ch_v    [MAX_CLUSTERS+1];
  logic              ch_have [MAX_CLUSTERS+1];
  logic [DIST_W-1:0] ch_dist [MAX_CLUSTERS+1];
  logic [KW-1:0]     ch_idx  [MAX_CLUSTERS+1];
  logic signed [COORD_BITS-1:0] coord_arr [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]      sum_arr   [MAX_CLUSTERS];
  logic [CNT_W-1:0]             cnt_arr   [MAX_CLUSTERS];

  logic                    last_v;
  logic [KW-1:0]           last_idx;
  logic signed [SUM_W-1:0] sum_sel;
  logic [CNT_W-1:0]        cnt_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic [NUM_W-1:0]        div_quo;
  logic [COORD_BITS-1:0]   quo_c;

  assign in_pi    = PW'(32'(in_data.point_index) % MAX_POINTS);
  assign in_ci    = KW'(32'(in_data.center_index) % MAX_CLUSTERS);
  assign in_di    = DW'(32'(in_data.dim_index) % MAX_DIMS);
  assign in_coord = COORD_BITS'(in_data.value);

  assign gives_result = (in_data.func == FUNC_START) || (in_data.func == FUNC_READ_LABEL) ||
                        (in_data.func == FUNC_READ_CENTER);
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall && gives_result);
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (num_points_r == 11'd0) begin
      np_m1 = '0;
    end else if (32'(num_points_r) > MAX_POINTS) begin
      np_m1 = PW'(MAX_POINTS - 1);
    end else begin
      np_m1 = PW'(num_points_r - 11'd1);
    end
    if (num_clusters_r == 5'd0) begin
      nk_m1 = '0;
    end else if (32'(num_clusters_r) > MAX_CLUSTERS) begin
      nk_m1 = KW'(MAX_CLUSTERS - 1);
    end else begin
      nk_m1 = KW'(num_clusters_r - 5'd1);
    end
    if (num_dims_r == 4'd0) begin
      nd_m1 = '0;
    end else if (32'(num_dims_r) > MAX_DIMS) begin
      nd_m1 = DW'(MAX_DIMS - 1);
    end else begin
      nd_m1 = DW'(num_dims_r - 4'd1);
    end
    limit = (max_passes_r == 16'd0) ? 16'd1 : max_passes_r;
  end

  // point store
  assign pm_we    = accept && (in_data.func == FUNC_LOAD_POINT);
  assign pm_waddr = AW'(32'(in_pi) * MAX_DIMS + 32'(in_di));
  assign pm_raddr = AW'(32'(p_r) * MAX_DIMS + 32'(d_r));

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_waddr] <= in_coord;
    end
    pmem_q <= pmem[pm_raddr];
  end

  // label store
  assign lm_we    = (state_r == ST_CHAIN) && last_v;
  assign lm_raddr = (state_r == ST_IDLE) ? in_pi : p_r;

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[p_r] <= last_idx;
    end
    lmem_q <= lmem[lm_raddr];
  end

  assign bus_dim   = iss_v_r ? iss_dim_r : wr_dim_r;
  assign bus_coord = iss_v_r ? pmem_q : wr_coord_r;

  always_comb begin
    ctl.clr_sums = (state_r == ST_PASS);
    ctl.clr_dist = (state_r == ST_PT) && (d_r == '0);
    ctl.dist_en  = iss_v_r && !iss_add_r;
    ctl.add_en   = iss_v_r && iss_add_r;
    ctl.cnt_inc  = (state_r == ST_ACC) && (d_r == '0);
    ctl.wr_en    = ld_r || upd_r;
  end

  assign ch_v[0]    = ch_v_r;
  assign ch_have[0] = 1'b0;
  assign ch_dist[0] = '0;
  assign ch_idx[0]  = '0;

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
    kml_cell #(
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W),
      .DIST_W     (DIST_W),
      .IDX_W      (KW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sel       (tgt_r == KW'(i)),
      .active    (KW'(i) <= nk_m1_r),
      .cell_idx  (KW'(i)),
      .bus_dim   (bus_dim),
      .bus_coord (bus_coord),
      .ch_v_i    (ch_v[i]),
      .ch_have_i (ch_have[i]),
      .ch_dist_i (ch_dist[i]),
      .ch_idx_i  (ch_idx[i]),
      .ch_v_o    (ch_v[i+1]),
      .ch_have_o (ch_have[i+1]),
      .ch_dist_o (ch_dist[i+1]),
      .ch_idx_o  (ch_idx[i+1]),
      .coord_o   (coord_arr[i]),
      .sum_o     (sum_arr[i]),
      .cnt_o     (cnt_arr[i])
    );
  end

  assign last_v   = ch_v[MAX_CLUSTERS];
  assign last_idx = ch_idx[MAX_CLUSTERS];
  assign sum_sel  = sum_arr[tgt_r];
  assign cnt_sel  = cnt_arr[tgt_r];
  assign sum_mag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

  assign div_start = (state_r == ST_UPD) && (cnt_sel != '0);
  assign div_num   = {sum_mag, 1'b0} + NUM_W'(cnt_sel);
  assign div_den   = {cnt_sel, 1'b0};

  kml_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_c    = div_quo[COORD_BITS-1:0];
  assign pass_inc = pass_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      num_points_r   <= 11'd1;
      num_clusters_r <= 5'd1;
      num_dims_r     <= 4'd1;
      max_passes_r   <= 16'd256;
      ld_r           <= 1'b0;
      upd_r          <= 1'b0;
      ch_v_r         <= 1'b0;
      iss_v_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      pass_r         <= '0;
      conv_r         <= 1'b0;
      changed_r      <= 1'b1;
    end else begin
      ld_r    <= 1'b0;
      upd_r   <= 1'b0;
      ch_v_r  <= 1'b0;
      iss_v_r <= 1'b0;
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_NUM_POINTS:   num_points_r   <= cfg_data[10:0];
          CFG_NUM_CLUSTERS: num_clusters_r <= cfg_data[4:0];
          CFG_NUM_DIMS:     num_dims_r     <= cfg_data[3:0];
          CFG_MAX_PASSES:   max_passes_r   <= cfg_data;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            priority case (in_data.func)
              FUNC_LOAD_CENTER: begin
                tgt_r      <= in_ci;
                wr_dim_r   <= in_di;
                wr_coord_r <= in_coord;
                ld_r       <= 1'b1;
              end
              FUNC_START: begin
                np_m1_r <= np_m1;
                nk_m1_r <= nk_m1;
                nd_m1_r <= nd_m1;
                limit_r <= limit;
                pass_r  <= '0;
                conv_r  <= 1'b0;
                state_r <= ST_PASS;
              end
              FUNC_READ_LABEL: begin
                state_r <= ST_RDL;
              end
              FUNC_READ_CENTER: begin
                tgt_r    <= in_ci;
                wr_dim_r <= in_di;
                state_r  <= ST_RDC;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RDL: begin
          out_valid_r <= 1'b1;
          out_data_r  <= '{kind: KIND_LABEL, label: 4'(lmem_q), coordinate: '0,
                           passes_run: '0, converged: 1'b0};
          state_r     <= ST_IDLE;
        end
        ST_RDC: begin
          out_valid_r <= 1'b1;
          out_data_r  <= '{kind: KIND_CENTER, label: '0, coordinate: 16'(coord_arr[tgt_r]),
                           passes_run: '0, converged: 1'b0};
          state_r     <= ST_IDLE;
        end
        ST_PASS: begin
          p_r       <= '0;
          d_r       <= '0;
          changed_r <= (pass_r == '0);
          state_r   <= ST_PT;
        end
        ST_PT: begin
          iss_v_r   <= 1'b1;
          iss_add_r <= 1'b0;
          iss_dim_r <= d_r;
          if (d_r == nd_m1_r) begin
            d_r     <= '0;
            wt_r    <= 2'd2;
            state_r <= ST_WAIT;
          end else begin
            d_r <= d_r + 1'b1;
          end
        end
        ST_WAIT: begin
          if (wt_r == 2'd0) begin
            ch_v_r  <= 1'b1;
            state_r <= ST_CHAIN;
          end else begin
            wt_r <= wt_r - 2'd1;
          end
        end
        ST_CHAIN: begin
          if (last_v) begin
            changed_r <= changed_r || (lmem_q != last_idx);
            tgt_r     <= last_idx;
            state_r   <= ST_ACC;
          end
        end
        ST_ACC: begin
          iss_v_r   <= 1'b1;
          iss_add_r <= 1'b1;
          iss_dim_r <= d_r;
          if (d_r == nd_m1_r) begin
            d_r <= '0;
            if (p_r == np_m1_r) begin
              state_r <= ST_DRAIN;
            end else begin
              p_r     <= p_r + 1'b1;
              state_r <= ST_PT;
            end
          end else begin
            d_r <= d_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          tgt_r    <= '0;
          wr_dim_r <= '0;
          state_r  <= ST_UPD;
        end
        ST_UPD: begin
          if (cnt_sel != '0) begin
            sign_r  <= sum_sel[SUM_W-1];
            state_r <= ST_DIV;
          end else if (tgt_r == nk_m1_r) begin
            state_r <= ST_PEND;
          end else begin
            tgt_r <= tgt_r + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            wr_coord_r <= sign_r ? COORD_BITS'(-quo_c) : COORD_BITS'(quo_c);
            upd_r      <= 1'b1;
            state_r    <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (wr_dim_r == nd_m1_r) begin
            wr_dim_r <= '0;
            if (tgt_r == nk_m1_r) begin
              state_r <= ST_PEND;
            end else begin
              tgt_r   <= tgt_r + 1'b1;
              state_r <= ST_UPD;
            end
          end else begin
            wr_dim_r <= wr_dim_r + 1'b1;
            state_r  <= ST_UPD;
          end
        end
        ST_PEND: begin
          pass_r <= pass_inc;
          if (!changed_r) begin
            conv_r  <= 1'b1;
            state_r <= ST_DONE;
          end else if (pass_inc >= limit_r) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_PASS;
          end
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          out_data_r  <= '{kind: KIND_STATUS, label: '0, coordinate: '0,
                           passes_run: pass_r, converged: conv_r};
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_chain_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    last_v |-> state_r == ST_CHAIN)
    else $error("chain result outside compare phase");

  a_div_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside update phase");

  a_upd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    upd_r |-> cnt_sel != '0)
    else $error("center update on empty cluster");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE || $past(state_r) == ST_RDL ||
                            $past(state_r) == ST_RDC))
    else $error("result beat from unexpected state");

endmodule
